>>> design/mwpa_pkg.sv
package mwpa_pkg;

    localparam int Window      = 16;
    localparam int PtrW        = 4;
    localparam int CntW        = 5;
    localparam int CordicSteps = 16;
    localparam int StepW       = 5;

    localparam logic signed [39:0] Q24Pi     = 40'sd52707179;
    localparam logic signed [39:0] Q24HalfPi = 40'sd26353589;
    localparam logic signed [39:0] Q24Gain   = 40'sd10188014;
    localparam int YawMax  = 25736;
    localparam int UnitQ14 = 16384;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SC,
        ST_SC_DONE,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_VEC,
        ST_VEC_DONE,
        ST_DIV,
        ST_OUT
    } state_t;

    // Arctangent table, Q24.
    function automatic logic signed [39:0] atan_q24(input logic [StepW-1:0] i);
        logic signed [39:0] r;
        unique case (i)
            5'd0:    r = 40'sd13176795;
            5'd1:    r = 40'sd7778717;
            5'd2:    r = 40'sd4110060;
            5'd3:    r = 40'sd2086331;
            5'd4:    r = 40'sd1047214;
            5'd5:    r = 40'sd524117;
            5'd6:    r = 40'sd262123;
            5'd7:    r = 40'sd131069;
            5'd8:    r = 40'sd65536;
            5'd9:    r = 40'sd32768;
            5'd10:   r = 40'sd16384;
            5'd11:   r = 40'sd8192;
            5'd12:   r = 40'sd4096;
            5'd13:   r = 40'sd2048;
            5'd14:   r = 40'sd1024;
            5'd15:   r = 40'sd512;
            5'd16:   r = 40'sd256;
            5'd17:   r = 40'sd128;
            5'd18:   r = 40'sd64;
            5'd19:   r = 40'sd32;
            5'd20:   r = 40'sd16;
            5'd21:   r = 40'sd8;
            5'd22:   r = 40'sd4;
            default: r = 40'sd2;
        endcase
        return r;
    endfunction

endpackage

>>> design/mwpa_ram.sv
module mwpa_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/mwpa_cordic.sv
module mwpa_cordic
    import mwpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  load,
    input  logic                  vec_mode,
    input  logic signed [39:0]    x_in,
    input  logic signed [39:0]    y_in,
    input  logic signed [39:0]    z_in,
    input  logic                  step_en,
    input  logic [StepW-1:0]      step,
    output logic signed [39:0]    x_out,
    output logic signed [39:0]    y_out,
    output logic signed [39:0]    z_out
);

    logic signed [39:0] x_reg, y_reg, z_reg;
    logic signed [39:0] x_sh, y_sh;
    logic               up;

    // One micro-rotation per cycle while step_en is high, shared by rotation and vectoring.
    always_comb
    begin
        x_sh = x_reg >>> step;
        y_sh = y_reg >>> step;
        up   = vec_mode ? (y_reg >= 0) : (z_reg >= 0);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
        else if (step_en)
        begin
            if (vec_mode == up)
            begin
                // Vectoring with y >= 0, or rotation with z < 0.
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
            end
            else
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
            end
            if (up == vec_mode)
            begin
                z_reg <= z_reg + atan_q24(step);
            end
            else
            begin
                z_reg <= z_reg - atan_q24(step);
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

>>> design/mwpa_div.sv
module mwpa_div
    import mwpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [35:0] dividend,
    input  logic [CntW-1:0]    divisor,
    output logic               busy,
    output logic signed [31:0] quotient
);

    // Restoring divider on magnitudes, one quotient bit per cycle.
    logic [35:0]     q_reg, q_next;
    logic [CntW:0]   r_reg, r_next;
    logic [CntW-1:0] d_reg;
    logic            neg_reg;
    logic [5:0]      cnt_reg;
    logic [CntW:0]   trial;

    always_comb
    begin
        trial  = {r_reg[CntW-1:0], q_reg[35]};
        q_next = {q_reg[34:0], 1'b0};
        r_next = trial;
        if (trial >= {1'b0, d_reg})
        begin
            r_next    = trial - {1'b0, d_reg};
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd36;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[35] ? 36'(-dividend) : 36'(dividend);
            neg_reg <= dividend[35];
            r_reg   <= '0;
            d_reg   <= divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign busy     = cnt_reg != 6'd0;
    assign quotient = neg_reg ? 32'(-q_reg) : 32'(q_reg);

endmodule

>>> design/moving_window_pose_average.sv
// Moving-window pose average.
// Input stream s_axis: one transaction is one pose sample (x, y, yaw).
// Output stream m_axis: one transaction per sample with the mean x, mean y,
// circular mean yaw and the number of samples held after that push.
// Configuration channel cfg: writes window_length (0 acts as 1, above 16 as 16);
// write it only while the block is idle. The new length applies at the next push.
// Each sample runs through one shared CORDIC: 16 rotation steps for sin/cos,
// a ring walk that reads back every held sample, vectoring for the mean
// heading, then a bit-serial divider for x and then y.
// s_axis_tready is high only while the block is idle; the next sample is taken
// once the result has left the output register.
// Reset empties the window, resets the write pointer and sets window_length to 16.
// When the receiver stalls, the result holds on m_axis and no new sample is taken.
module moving_window_pose_average
    import mwpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: pose_x [31:0], pose_y [63:32], pose_yaw [79:64]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: mean_x [31:0], mean_y [63:32], mean_yaw [79:64], held_count [84:80], zero [87:85]
    output logic [87:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    state_t state_reg, state_next;

    logic [CntW-1:0]    wlen_reg;
    logic [PtrW-1:0]    wptr_reg;
    logic [CntW-1:0]    fill_reg;
    logic [StepW-1:0]   step_reg;
    logic [CntW-1:0]    walk_reg;
    logic [PtrW-1:0]    ridx_reg;
    logic               flip_reg;
    logic               ydiv_reg;
    logic signed [31:0] in_x_reg, in_y_reg;
    logic signed [15:0] in_yaw_reg;
    logic signed [35:0] sum_x_reg, sum_y_reg;
    logic signed [20:0] sum_c_reg, sum_s_reg;
    logic signed [31:0] mx_reg;
    logic [87:0]        out_reg;

    // Ring memory: {sin, cos, y, x}.
    logic        ram_we;
    logic [95:0] ram_rdata;
    logic signed [15:0] c_q14, s_q14;

    // CORDIC controls.
    logic               cd_load, cd_vec, cd_step;
    logic signed [39:0] cd_xi, cd_yi, cd_zi, cd_x, cd_y, cd_z;

    logic               dv_start, dv_busy;
    logic signed [35:0] dv_dividend;
    logic signed [31:0] dv_q;

    logic signed [39:0] z0;
    logic signed [39:0] xr, yr, zr;
    logic signed [29:0] cr, sr, ar;
    logic signed [15:0] yaw_q13;
    logic [CntW-1:0]    kept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_reg;

    // Sin/cos rounding to Q1.14 and mean heading rounding to Q3.13, each with clamp.
    always_comb
    begin
        xr = flip_reg ? -cd_x : cd_x;
        yr = flip_reg ? -cd_y : cd_y;
        cr = 30'((xr + 40'sd512) >>> 10);
        sr = 30'((yr + 40'sd512) >>> 10);
        c_q14 = (cr > 30'sd16384) ? 16'sd16384 : (cr < -30'sd16384) ? -16'sd16384 : 16'(cr);
        s_q14 = (sr > 30'sd16384) ? 16'sd16384 : (sr < -30'sd16384) ? -16'sd16384 : 16'(sr);
        ar = 30'((cd_z + 40'sd1024) >>> 11);
        yaw_q13 = (ar > 30'sd25736) ? 16'sd25736 : (ar < -30'sd25736) ? -16'sd25736 : 16'(ar);
        z0 = 40'(in_yaw_reg) <<< 11;
        zr = 40'(signed'(s_axis_tdata[79:64])) <<< 11;
        kept = (fill_reg > wlen_reg - 5'd1) ? wlen_reg - 5'd1 : fill_reg;
    end

    mwpa_ram #(.WIDTH(96), .DEPTH(Window)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata ({s_q14, c_q14, in_y_reg, in_x_reg}),
        .raddr (ridx_reg),
        .rdata (ram_rdata)
    );

    mwpa_cordic u_cordic (
        .clk      (clk),
        .load     (cd_load),
        .vec_mode (cd_vec),
        .x_in     (cd_xi),
        .y_in     (cd_yi),
        .z_in     (cd_zi),
        .step_en  (cd_step),
        .step     (step_reg),
        .x_out    (cd_x),
        .y_out    (cd_y),
        .z_out    (cd_z)
    );

    mwpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_dividend),
        .divisor  (fill_reg),
        .busy     (dv_busy),
        .quotient (dv_q)
    );

    // Sequencer next state and unit controls.
    always_comb
    begin
        state_next  = state_reg;
        cd_load     = 1'b0;
        cd_vec      = 1'b0;
        cd_step     = 1'b0;
        cd_xi       = Q24Gain;
        cd_yi       = '0;
        cd_zi       = z0;
        ram_we      = 1'b0;
        dv_start    = 1'b0;
        dv_dividend = ydiv_reg ? sum_y_reg : sum_x_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_SC;
                end
            end
            ST_SC:
            begin
                cd_step = 1'b1;
                if (step_reg == 5'(CordicSteps - 1))
                begin
                    state_next = ST_SC_DONE;
                end
            end
            ST_SC_DONE:
            begin
                ram_we     = 1'b1;
                state_next = ST_SUM_RD;
            end
            ST_SUM_RD:
            begin
                state_next = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                if (walk_reg == 5'd1)
                begin
                    state_next = ST_VEC;
                end
                else
                begin
                    state_next = ST_SUM_RD;
                end
            end
            ST_VEC:
            begin
                cd_vec = 1'b1;
                if (step_reg == 5'd31)
                begin
                    cd_load = 1'b1;
                    cd_xi   = 40'(sum_c_reg[20] ? -sum_c_reg : sum_c_reg) <<< 16;
                    cd_yi   = 40'(sum_c_reg[20] ? -sum_s_reg : sum_s_reg) <<< 16;
                    cd_zi   = sum_c_reg[20] ? (sum_s_reg[20] ? -Q24Pi : Q24Pi) : '0;
                end
                else
                begin
                    cd_step = 1'b1;
                    if (step_reg == 5'(CordicSteps - 1))
                    begin
                        state_next = ST_VEC_DONE;
                    end
                end
            end
            ST_VEC_DONE:
            begin
                dv_start   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!dv_busy && ydiv_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (!dv_busy)
                begin
                    dv_start    = 1'b1;
                    dv_dividend = sum_y_reg;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Fold the incoming heading into plus or minus pi/2 for the rotation.
        if (state_reg == ST_IDLE)
        begin
            cd_load = s_axis_tvalid;
            if (zr > Q24HalfPi)
            begin
                cd_zi = zr - Q24Pi;
            end
            else if (zr < -Q24HalfPi)
            begin
                cd_zi = zr + Q24Pi;
            end
            else
            begin
                cd_zi = zr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wlen_reg  <= 5'd16;
            wptr_reg  <= '0;
            fill_reg  <= '0;
            step_reg  <= '0;
            walk_reg  <= '0;
            ridx_reg  <= '0;
            ydiv_reg  <= 1'b0;
            flip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                wlen_reg <= (cfg_data == 5'd0) ? 5'd1 :
                            (cfg_data > 5'(Window)) ? 5'(Window) : cfg_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    ydiv_reg <= 1'b0;
                    if (s_axis_tvalid)
                    begin
                        flip_reg <= (zr > Q24HalfPi) || (zr < -Q24HalfPi);
                    end
                end
                ST_SC:
                begin
                    step_reg <= step_reg + 5'd1;
                end
                ST_SC_DONE:
                begin
                    fill_reg <= kept + 5'd1;
                    walk_reg <= kept + 5'd1;
                    ridx_reg <= wptr_reg;
                    wptr_reg <= wptr_reg + 4'd1;
                    step_reg <= 5'd31;
                end
                ST_SUM_ACC:
                begin
                    walk_reg <= walk_reg - 5'd1;
                    ridx_reg <= ridx_reg - 4'd1;
                end
                ST_VEC:
                begin
                    step_reg <= step_reg + 5'd1;
                end
                ST_DIV:
                begin
                    if (!dv_busy && !ydiv_reg)
                    begin
                        ydiv_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            in_x_reg   <= s_axis_tdata[31:0];
            in_y_reg   <= s_axis_tdata[63:32];
            in_yaw_reg <= s_axis_tdata[79:64];
        end
        if (state_reg == ST_SC_DONE)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_c_reg <= '0;
            sum_s_reg <= '0;
        end
        if (state_reg == ST_SUM_ACC)
        begin
            sum_x_reg <= sum_x_reg + 36'(signed'(ram_rdata[31:0]));
            sum_y_reg <= sum_y_reg + 36'(signed'(ram_rdata[63:32]));
            sum_c_reg <= sum_c_reg + 21'(signed'(ram_rdata[79:64]));
            sum_s_reg <= sum_s_reg + 21'(signed'(ram_rdata[95:80]));
        end
        if (state_reg == ST_VEC_DONE)
        begin
            out_reg[79:64] <= (sum_c_reg == 21'sd0 && sum_s_reg == 21'sd0) ? 16'sd0 : yaw_q13;
            out_reg[84:80] <= fill_reg;
            out_reg[87:85] <= '0;
        end
        if (state_reg == ST_DIV && !dv_busy)
        begin
            if (ydiv_reg)
            begin
                out_reg[31:0]  <= mx_reg;
                out_reg[63:32] <= dv_q;
            end
            else
            begin
                mx_reg <= dv_q;
            end
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 5'(Window)) else $error("fill count beyond window");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
`endif

endmodule

>>> sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PiQ24     = 52707179;
    localparam longint HalfPiQ24 = 26353589;
    localparam longint GainQ24   = 10188014;
    localparam longint YawLimit  = 25736;
    localparam longint UnitQ14v  = 16384;
    localparam int     RingDepth = 16;
    localparam int     Steps     = 16;
    localparam int     SettleCycles = 300;

    localparam longint ArctanQ24 [0:15] = '{
        13176795, 7778717, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
    };

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } pose_t;

    typedef struct packed {
        logic [2:0]         pad;
        logic [4:0]         held;
        logic signed [15:0] yaw;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } pose_mean_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    // Predictor state: the pose window and its length.
    logic signed [31:0] win_x   [RingDepth];
    logic signed [31:0] win_y   [RingDepth];
    logic signed [15:0] win_cos [RingDepth];
    logic signed [15:0] win_sin [RingDepth];
    int unsigned        head_ptr = 0;
    int unsigned        held_samples = 0;
    int unsigned        window_len = 16;

    pose_t      pose_queue [$];
    pose_mean_t mean_queue [$];
    int         error_count = 0;
    int         mean_count = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    int         hold_request = 0;
    int         hold_left = 0;
    bit         pose_taken = 1'b0;

    always #5 clk = ~clk;

    moving_window_pose_average dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Rotation CORDIC: heading in Q3.13 to cosine and sine in Q1.14.
    task automatic heading_to_unit(input logic signed [15:0] yaw,
                                   output logic signed [15:0] c,
                                   output logic signed [15:0] s);
        longint z, vx, vy, t;
        bit     folded;
        z = longint'(yaw) * 2048;
        vx = GainQ24;
        vy = 0;
        folded = 1'b0;
        if (z > HalfPiQ24)
        begin
            z -= PiQ24;
            folded = 1'b1;
        end
        else if (z < -HalfPiQ24)
        begin
            z += PiQ24;
            folded = 1'b1;
        end
        for (int i = 0; i < Steps; i++)
        begin
            if (z >= 0)
            begin
                t = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                vx = t;
                z -= ArctanQ24[i];
            end
            else
            begin
                t = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                vx = t;
                z += ArctanQ24[i];
            end
        end
        if (folded)
        begin
            vx = -vx;
            vy = -vy;
        end
        t = (vx + 512) >>> 10;
        c = 16'(t > UnitQ14v ? UnitQ14v : (t < -UnitQ14v ? -UnitQ14v : t));
        t = (vy + 512) >>> 10;
        s = 16'(t > UnitQ14v ? UnitQ14v : (t < -UnitQ14v ? -UnitQ14v : t));
    endtask

    // Vectoring CORDIC: circular mean heading from summed sine and cosine.
    function automatic logic signed [15:0] mean_heading(input longint sum_s,
                                                        input longint sum_c);
        longint vx, vy, z, t;
        if (sum_s == 0 && sum_c == 0)
            return '0;
        z = 0;
        if (sum_c < 0)
        begin
            z = (sum_s >= 0) ? PiQ24 : -PiQ24;
            sum_c = -sum_c;
            sum_s = -sum_s;
        end
        vx = sum_c * 65536;
        vy = sum_s * 65536;
        for (int i = 0; i < Steps; i++)
        begin
            if (vy >= 0)
            begin
                t = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                vx = t;
                z += ArctanQ24[i];
            end
            else
            begin
                t = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                vx = t;
                z -= ArctanQ24[i];
            end
        end
        t = (z + 1024) >>> 11;
        return 16'(t > YawLimit ? YawLimit : (t < -YawLimit ? -YawLimit : t));
    endfunction

    // Push one sample into the predicted window and queue the expected mean.
    task automatic push_pose(input pose_t p);
        int unsigned        idx;
        longint             sx, sy, sc, ss;
        logic signed [15:0] c, s;
        pose_mean_t         m;
        held_samples = (held_samples > window_len - 1) ? window_len - 1 : held_samples;
        held_samples++;
        idx = head_ptr;
        heading_to_unit(p.yaw, c, s);
        win_x[idx] = p.x;
        win_y[idx] = p.y;
        win_cos[idx] = c;
        win_sin[idx] = s;
        head_ptr = (idx + 1) % RingDepth;
        sx = 0; sy = 0; sc = 0; ss = 0;
        for (int k = 0; k < held_samples; k++)
        begin
            sx += win_x[idx];
            sy += win_y[idx];
            sc += win_cos[idx];
            ss += win_sin[idx];
            idx = (idx == 0) ? RingDepth - 1 : idx - 1;
        end
        m.pad = '0;
        m.held = 5'(held_samples);
        m.yaw = mean_heading(ss, sc);
        m.x = 32'(sx / longint'(held_samples));
        m.y = 32'(sy / longint'(held_samples));
        mean_queue.push_back(m);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // Input driver: holds a sample until its transaction completes.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !pose_taken)
                ;
            else if (pose_queue.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_axis_tdata <= pose_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
            pose_taken = 1'b0;
        end
    end

    // Output backpressure, with an optional long hold-off.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: predict on input transactions, check output transactions.
    always @(posedge clk)
    begin
        pose_mean_t got, want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            push_pose(pose_t'(s_axis_tdata));
            pose_taken = 1'b1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = pose_mean_t'(m_axis_tdata);
            mean_count++;
            if (mean_queue.size() == 0)
                report_mismatch("unexpected result", got.x, 0);
            else
            begin
                want = mean_queue.pop_front();
                if (got.x !== want.x)
                    report_mismatch("mean_x", got.x, want.x);
                if (got.y !== want.y)
                    report_mismatch("mean_y", got.y, want.y);
                if (got.yaw !== want.yaw)
                    report_mismatch("mean_yaw", 32'(got.yaw), 32'(want.yaw));
                if (got.held !== want.held)
                    report_mismatch("held_count", 32'(got.held), 32'(want.held));
                if (got.pad !== 3'b000)
                    report_mismatch("pad bits", 32'(got.pad), 0);
            end
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pose_queue.size() != 0 || s_axis_tvalid || mean_queue.size() != 0);
    endtask

    task automatic set_window(input logic [4:0] len);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        window_len = (len == 0) ? 1 : (len > RingDepth ? RingDepth : len);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pose(input logic [31:0] x, input logic [31:0] y,
                              input logic [15:0] yaw);
        pose_queue.push_back('{yaw: yaw, y: y, x: x});
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_heading();
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(51472)) - 16'd25736;
    endfunction

    initial
    begin
        logic [4:0] lengths [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd5, 5'd17, 5'd9};
        for (int i = 0; i < RingDepth; i++)
        begin
            win_x[i] = '0; win_y[i] = '0; win_cos[i] = '0; win_sin[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme fields, heading folding, cancelling headings.
        queue_pose(32'h7fff_ffff, 32'h8000_0000, 16'sd25736);
        queue_pose(32'h7fff_ffff, 32'h8000_0000, -16'sd25736);
        queue_pose(32'h8000_0000, 32'h7fff_ffff, 16'sd0);
        queue_pose(32'hffff_ffff, 32'h0000_0001, 16'h7fff);
        queue_pose(32'h0, 32'h0, 16'h8000);
        queue_pose(32'h1, 32'hffff_ffff, 16'sd12868);
        queue_pose(32'h0, 32'h0, -16'sd12868);
        for (int i = 0; i < 12; i++)
            queue_pose(32'h7fff_ffff, 32'h8000_0000, 16'sd20000);
        wait_drained();
        set_window(5'd2);
        queue_pose(32'h5, 32'hfffffffb, 16'sd0);
        queue_pose(32'h6, 32'hfffffffa, 16'sd25736);
        queue_pose(32'h7, 32'h7, 16'sd12868);
        queue_pose(32'h8, 32'h8, -16'sd12868);
        wait_drained();
        set_window(5'd1);
        queue_pose(32'h0, 32'h0, 16'sd25736);
        queue_pose(32'h0, 32'h0, -16'sd25736);
        wait_drained();

        // Random phases across window lengths and idle patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            set_window(lengths[ph]);
            src_idle_pct = (ph % 4 == 1) ? 46 : (ph % 4 == 3 ? 25 : 0);
            sink_stall_pct = (ph % 4 == 2) ? 46 : (ph % 4 == 3 ? 25 : 0);
            for (int i = 0; i < 120; i++)
                queue_pose(rand_coord(), rand_coord(), rand_heading());
            if (ph == 2)
                hold_request = 2000;
            wait_drained();
        end

        repeat (SettleCycles) @(posedge clk);
        $display("Covered %0d results over window lengths 0..31 with idle and stall phases,",
                 mean_count);
        $display("including a long receiver hold-off and heading folding past pi.");
        if (error_count == 0 && mean_queue.size() == 0)
            $display("moving_window_pose_average: match");
        else
            $display("moving_window_pose_average: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("moving_window_pose_average: mismatch");
        $finish;
    end

endmodule
